[design/stk_pkg.sv]
// Shared constants, command codes and types for the score table top-k block.
// No dependencies; stk_unit and the top level refer to it by scoped name.
`timescale 1ns / 1ps

package stk_pkg;

	localparam int POINTS  = 512;
	localparam int MAX_K   = 16;
	localparam int IDX_W   = $clog2(POINTS);
	localparam int CNT_W   = IDX_W + 1;
	localparam int K_W     = $clog2(MAX_K + 1);

	// Fixed field widths of the stream payload
	localparam int CMD_W   = 3;
	localparam int PT_W    = 9;
	localparam int SC_W    = 32;
	localparam int COUNT_W = 5;
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 48;
	localparam int M_PAD_W   = M_TDATA_W - PT_W - SC_W;

	localparam logic [CMD_W-1:0] CMD_SET_REL = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ADD     = 3'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_TOPK    = 3'd4;

	localparam logic signed [SC_W-1:0] SCORE_MIN = {1'b1, {(SC_W-1){1'b0}}};
	localparam logic signed [SC_W-1:0] SCORE_MAX = {1'b0, {(SC_W-1){1'b1}}};

	// Last pick of a top-k run: later scans only take entries ranked below it
	typedef struct packed {
		logic                    valid;
		logic signed [SC_W-1:0]  score;
		logic [IDX_W-1:0]        idx;
	} thr_t;

	typedef struct packed {
		logic signed [SC_W-1:0]  sum;
		logic                    better;
	} unit_res_t;

endpackage

[design/stk_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module stk_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/stk_unit.sv]
// Shared arithmetic and compare unit: saturating add for updates, rank compare for scans.
// Depends on stk_pkg.
`timescale 1ns / 1ps

module stk_unit (
	input  logic [stk_pkg::SC_W-1:0]   entry,
	input  logic [stk_pkg::IDX_W-1:0]  idx,
	input  logic [stk_pkg::SC_W-1:0]   delta,
	input  logic [stk_pkg::SC_W-1:0]   top,
	input  stk_pkg::thr_t              thr,
	output stk_pkg::unit_res_t         res
);

	logic signed [stk_pkg::SC_W:0] sum_w;
	logic                          eligible;

	always_comb begin
		sum_w = $signed({entry[stk_pkg::SC_W-1], entry})
			+ $signed({delta[stk_pkg::SC_W-1], delta});
		// Clamp when the carry-out disagrees with the sign bit
		if (sum_w[stk_pkg::SC_W] != sum_w[stk_pkg::SC_W-1]) begin
			res.sum = sum_w[stk_pkg::SC_W] ? stk_pkg::SCORE_MIN : stk_pkg::SCORE_MAX;
		end else begin
			res.sum = sum_w[stk_pkg::SC_W-1:0];
		end

		// Entries already listed rank at or above the last pick: higher score,
		// or equal score at a lower or equal index
		eligible = !thr.valid
			|| ($signed(entry) < $signed(thr.score))
			|| ((entry == thr.score) && (idx > thr.idx));
		res.better = eligible && ($signed(entry) > $signed(top));
	end

endmodule

[design/score_table_top_k_top.sv]
// Top level of the score table with running best and top-k listing.
// Depends on stk_pkg, stk_ram and stk_unit.
`timescale 1ns / 1ps

// Usage
// Input stream (s_*): one command per transfer. s_tuser carries the command code,
// s_tdata the operands. Output stream (m_*): result transfers; m_tlast marks the
// final result of a command, m_tuser flags "no best point yet".
// Commands: set relevance and clear give no result; add and query give one;
// top-k gives min(count, MAX_K) results, none for a count of zero.
// Command handling (from the input transfer):
//   set relevance, query, unknown codes: handled at the accepting edge, query result loaded there.
//   add: a read-modify-write of one score RAM entry.
//   clear: one RAM entry zeroed per cycle.
//   top-k: each result is a full scan of the score RAM through its single read port,
//   one entry per cycle, into the rank compare.
// One command at a time: s_tready is low while a command is in flight.
// Reset: asynchronous, active low. After release the block sweeps both RAMs to
// zero with s_tready low.
// Output stall: results sit in an output register; while m_tready is low the
// register holds and the sequencer waits before loading the next result.
module score_table_top_k_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// point [8:0], delta [40:9], relevant_flag [41], count [46:42], zero [47]
	input  logic [stk_pkg::S_TDATA_W-1:0]  s_tdata,
	// cmd [2:0]
	input  logic [stk_pkg::CMD_W-1:0]      s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// result_point [8:0], score [40:9], zero [47:41]
	output logic [stk_pkg::M_TDATA_W-1:0]  m_tdata,
	// is_pass [0]
	output logic                           m_tuser,
	output logic                           m_tlast
);

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_ADD  = 3'd2;
	localparam logic [2:0] ST_SCAN = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	// Input field decode
	logic [stk_pkg::CMD_W-1:0]    in_cmd;
	logic [stk_pkg::PT_W-1:0]     in_point;
	logic [stk_pkg::SC_W-1:0]     in_delta;
	logic                         in_flag;
	logic [stk_pkg::COUNT_W-1:0]  in_count;
	logic [31:0]                  pt_ext;
	logic                         in_range;
	logic [stk_pkg::IDX_W-1:0]    in_addr;
	logic [stk_pkg::K_W-1:0]      n_sat;

	// Sequencer state
	logic [2:0]                   state_q;
	logic [stk_pkg::CNT_W-1:0]    cnt_q;
	logic                         clr_rel_q;
	logic [stk_pkg::PT_W-1:0]     pt_q;
	logic [stk_pkg::IDX_W-1:0]    pt_addr_q;
	logic                         in_range_q;
	logic [stk_pkg::SC_W-1:0]     delta_q;
	logic [stk_pkg::K_W-1:0]      rem_q;
	logic                         rd_vld_s1;
	logic [stk_pkg::IDX_W-1:0]    rd_idx_s1;
	logic signed [stk_pkg::SC_W-1:0] top_q;
	logic [stk_pkg::IDX_W-1:0]    sel_q;
	logic                         found_q;
	logic [stk_pkg::SC_W-1:0]     zero_q;
	stk_pkg::thr_t                thr_q;

	// Running best
	logic signed [stk_pkg::SC_W-1:0] best_score_q;
	logic [stk_pkg::IDX_W-1:0]    best_point_q;
	logic                         best_valid_q;

	// Output register
	logic                         m_tvalid_q;
	logic [stk_pkg::PT_W-1:0]     out_point_q;
	logic                         out_pass_q;
	logic [stk_pkg::SC_W-1:0]     out_score_q;
	logic                         out_last_q;
	logic                         out_load;
	logic [stk_pkg::PT_W-1:0]     out_point_d;
	logic                         out_pass_d;
	logic [stk_pkg::SC_W-1:0]     out_score_d;
	logic                         out_last_d;

	// RAM ports
	logic                         sc_we;
	logic [stk_pkg::IDX_W-1:0]    sc_waddr;
	logic [stk_pkg::SC_W-1:0]     sc_wdata;
	logic                         sc_re;
	logic [stk_pkg::IDX_W-1:0]    sc_raddr;
	logic [stk_pkg::SC_W-1:0]     sc_rdata;
	logic                         rel_we;
	logic [stk_pkg::IDX_W-1:0]    rel_waddr;
	logic                         rel_wdata;
	logic                         rel_re;
	logic                         rel_rdata;

	stk_pkg::unit_res_t           ures;

	logic slot_free;
	logic accept;
	logic cnt_done;
	logic add_hit;
	logic new_best;

	assign in_cmd   = s_tuser;
	assign in_point = s_tdata[8:0];
	assign in_delta = s_tdata[40:9];
	assign in_flag  = s_tdata[41];
	assign in_count = s_tdata[46:42];
	assign pt_ext   = 32'(in_point);
	assign in_range = pt_ext < 32'(stk_pkg::POINTS);
	assign in_addr  = pt_ext[stk_pkg::IDX_W-1:0];
	assign n_sat    = (32'(in_count) > 32'(stk_pkg::MAX_K))
		? stk_pkg::K_W'(stk_pkg::MAX_K) : stk_pkg::K_W'(in_count);

	assign slot_free = !m_tvalid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE) && slot_free;
	assign accept    = s_tvalid && s_tready;
	assign cnt_done  = cnt_q == stk_pkg::CNT_W'(stk_pkg::POINTS);
	assign add_hit   = in_range_q && rel_rdata;
	assign new_best  = add_hit && (!best_valid_q || ($signed(ures.sum) > best_score_q));

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{stk_pkg::M_PAD_W{1'b0}}, out_score_q, out_point_q};
	assign m_tuser  = out_pass_q;
	assign m_tlast  = out_last_q;

	stk_ram #(
		.WIDTH (stk_pkg::SC_W),
		.DEPTH (stk_pkg::POINTS)
	) u_score_ram (
		.clk   (clk),
		.we    (sc_we),
		.waddr (sc_waddr),
		.wdata (sc_wdata),
		.re    (sc_re),
		.raddr (sc_raddr),
		.rdata (sc_rdata)
	);

	stk_ram #(
		.WIDTH (1),
		.DEPTH (stk_pkg::POINTS)
	) u_rel_ram (
		.clk   (clk),
		.we    (rel_we),
		.waddr (rel_waddr),
		.wdata (rel_wdata),
		.re    (rel_re),
		.raddr (in_addr),
		.rdata (rel_rdata)
	);

	// Shared unit: sums for add, rank compare for the scan
	stk_unit u_unit (
		.entry (sc_rdata),
		.idx   (rd_idx_s1),
		.delta (delta_q),
		.top   (top_q),
		.thr   (thr_q),
		.res   (ures)
	);

	// RAM access and output load per state
	always_comb begin
		sc_we       = 1'b0;
		sc_waddr    = cnt_q[stk_pkg::IDX_W-1:0];
		sc_wdata    = '0;
		sc_re       = 1'b0;
		sc_raddr    = in_addr;
		rel_we      = 1'b0;
		rel_waddr   = cnt_q[stk_pkg::IDX_W-1:0];
		rel_wdata   = 1'b0;
		rel_re      = 1'b0;
		out_load    = 1'b0;
		out_point_d = pt_q;
		out_pass_d  = !best_valid_q;
		out_score_d = best_score_q;
		out_last_d  = 1'b1;
		unique case (state_q)
			ST_CLR: begin
				// Zero one entry per cycle; relevance too after reset
				sc_we  = 1'b1;
				rel_we = clr_rel_q;
			end
			ST_IDLE: begin
				sc_re     = accept && (in_cmd == stk_pkg::CMD_ADD);
				rel_re    = accept && (in_cmd == stk_pkg::CMD_ADD);
				rel_we    = accept && (in_cmd == stk_pkg::CMD_SET_REL) && in_range;
				rel_waddr = in_addr;
				rel_wdata = in_flag;
				out_load  = accept && (in_cmd == stk_pkg::CMD_QUERY);
				out_point_d = stk_pkg::PT_W'(best_point_q);
			end
			ST_ADD: begin
				sc_we    = slot_free && add_hit;
				sc_waddr = pt_addr_q;
				sc_wdata = ures.sum;
				out_load = slot_free;
				out_pass_d = !(best_valid_q || add_hit);
				if (!in_range_q) begin
					out_score_d = '0;
				end else if (add_hit) begin
					out_score_d = ures.sum;
				end else begin
					out_score_d = sc_rdata;
				end
			end
			ST_SCAN: begin
				sc_re    = !cnt_done;
				sc_raddr = cnt_q[stk_pkg::IDX_W-1:0];
			end
			ST_EMIT: begin
				out_load    = slot_free;
				out_point_d = found_q ? stk_pkg::PT_W'(sel_q) : '0;
				out_pass_d  = 1'b0;
				out_score_d = found_q ? top_q : zero_q;
				out_last_d  = rem_q == stk_pkg::K_W'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			cnt_q        <= '0;
			clr_rel_q    <= 1'b1;
			pt_q         <= '0;
			pt_addr_q    <= '0;
			in_range_q   <= 1'b0;
			delta_q      <= '0;
			rem_q        <= '0;
			rd_vld_s1    <= 1'b0;
			rd_idx_s1    <= '0;
			top_q        <= stk_pkg::SCORE_MIN;
			sel_q        <= '0;
			found_q      <= 1'b0;
			zero_q       <= '0;
			thr_q        <= '0;
			best_score_q <= stk_pkg::SCORE_MIN;
			best_point_q <= '0;
			best_valid_q <= 1'b0;
			m_tvalid_q   <= 1'b0;
			out_point_q  <= '0;
			out_pass_q   <= 1'b0;
			out_score_q  <= '0;
			out_last_q   <= 1'b0;
		end else begin
			// Output register: load a new result, else drop it once transferred
			if (out_load) begin
				m_tvalid_q  <= 1'b1;
				out_point_q <= out_point_d;
				out_pass_q  <= out_pass_d;
				out_score_q <= out_score_d;
				out_last_q  <= out_last_d;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == stk_pkg::CNT_W'(stk_pkg::POINTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						unique case (in_cmd)
							stk_pkg::CMD_ADD: begin
								pt_q       <= in_point;
								pt_addr_q  <= in_addr;
								in_range_q <= in_range;
								delta_q    <= in_delta;
								state_q    <= ST_ADD;
							end
							stk_pkg::CMD_CLEAR: begin
								cnt_q     <= '0;
								clr_rel_q <= 1'b0;
								state_q   <= ST_CLR;
							end
							stk_pkg::CMD_TOPK: begin
								if (n_sat != '0) begin
									rem_q       <= n_sat;
									thr_q.valid <= 1'b0;
									cnt_q       <= '0;
									top_q       <= stk_pkg::SCORE_MIN;
									sel_q       <= '0;
									found_q     <= 1'b0;
									state_q     <= ST_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_ADD: begin
					// Hold until the output register can take the result
					if (slot_free) begin
						if (new_best) begin
							best_score_q <= ures.sum;
							best_point_q <= pt_addr_q;
							best_valid_q <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (!cnt_done) begin
						cnt_q <= cnt_q + 1'b1;
					end
					rd_vld_s1 <= !cnt_done;
					rd_idx_s1 <= cnt_q[stk_pkg::IDX_W-1:0];
					if (rd_vld_s1) begin
						if (rd_idx_s1 == '0) begin
							zero_q <= sc_rdata;
						end
						if (ures.better) begin
							top_q   <= sc_rdata;
							sel_q   <= rd_idx_s1;
							found_q <= 1'b1;
						end
					end
					if (cnt_done && !rd_vld_s1) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						if (found_q) begin
							thr_q.valid <= 1'b1;
							thr_q.score <= top_q;
							thr_q.idx   <= sel_q;
						end
						if (rem_q == stk_pkg::K_W'(1)) begin
							state_q <= ST_IDLE;
						end else begin
							// Advance to the next scan
							rem_q   <= rem_q - 1'b1;
							cnt_q   <= '0;
							top_q   <= stk_pkg::SCORE_MIN;
							sel_q   <= '0;
							found_q <= 1'b0;
							state_q <= ST_SCAN;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Once a best exists it never goes away
	a_best_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		best_valid_q |=> best_valid_q)
		else $error("running best lost its valid flag");

	// Without a best, the best registers keep their reset values
	a_best_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!best_valid_q |-> (best_score_q == stk_pkg::SCORE_MIN) && (best_point_q == '0))
		else $error("best registers changed without a valid best");

	// A found pick never ranks above the previous pick of the same run
	a_rank_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) && found_q && thr_q.valid |->
		($signed(top_q) < $signed(thr_q.score))
		|| ((top_q == thr_q.score) && (sel_q > thr_q.idx)))
		else $error("top-k pick out of rank order");

	// A scan only finds entries above the most negative score
	a_found_above_min: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) && found_q |-> top_q != stk_pkg::SCORE_MIN)
		else $error("scan picked an entry at the most negative score");

	// A top-k run always has results left while it scans or emits
	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) || (state_q == ST_EMIT) |-> rem_q != '0)
		else $error("top-k run with no results left");

endmodule
